[rtl/core/fskid_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fskid_pkg
// Shared types, constants and helpers for the fsk identifier deframer.
// ---------------------------------------------------------------------------
package fskid_pkg;

	localparam int POWER_WIDTH        = 32;
	localparam int QUEUE_DEPTH_DEF    = 2;
	localparam int HUNT_WIDTH         = 10;
	localparam int CHAR_CNT_WIDTH     = 4;
	localparam int CFG_DATA_WIDTH     = 10;
	localparam int HIST_LEN           = 24;

	localparam logic [HUNT_WIDTH-1:0]     HUNT_LIMIT_RST = 10'd200;
	localparam logic [CHAR_CNT_WIDTH-1:0] CHAR_LIMIT_RST = 4'd10;
	localparam logic [HUNT_WIDTH-1:0]     HUNT_SAT       = 10'h3FF;

	localparam logic [5:0] SYNC_FIRST   = 6'h20;
	localparam logic [5:0] SYNC_SECOND  = 6'h2A;
	localparam logic [5:0] TERM_BELOW   = 6'h0D;
	localparam logic [6:0] ASCII_OFFSET = 7'h20;
	localparam logic [2:0] BITS_PER_CHAR = 3'd6;

	typedef enum logic {
		CFG_HUNT_LIMIT = 1'b0,
		CFG_CHAR_LIMIT = 1'b1
	} cfg_index_t;

	typedef enum logic {
		CMD_WINDOW  = 1'b0,
		CMD_RESTART = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		ST_RUNNING      = 2'd0,
		ST_TERMINATOR   = 2'd1,
		ST_CHAR_LIMIT   = 2'd2,
		ST_HUNT_TIMEOUT = 2'd3
	} end_status_t;

	typedef struct packed {
		logic                   cmd;
		logic [POWER_WIDTH-1:0] low_tone_power;
		logic [POWER_WIDTH-1:0] high_tone_power;
	} in_item_t;

	typedef struct packed {
		logic        char_valid;
		logic [6:0]  char_code;
		logic        synced;
		end_status_t status;
		logic        full_bit_advance;
		logic [CHAR_CNT_WIDTH-1:0] char_total;
	} out_item_t;

	// classified window handed from front to back
	typedef struct packed {
		cmd_t cmd;
		logic bit_val;
	} op_t;

	function automatic logic [5:0] rev6(input logic [5:0] v);
		logic [5:0] r;
		r = '0;
		for (int k = 0; k < 6; k++) begin
			r[5-k] = v[k];
		end
		return r;
	endfunction

	// every other history bit, oldest first, two reversed groups
	function automatic logic sync_hit(input logic [HIST_LEN-1:0] hist);
		logic [11:0] picked;
		picked = '0;
		for (int i = 0; i < 12; i++) begin
			picked[11-i] = hist[23-2*i];
		end
		return (rev6(picked[11:6]) == SYNC_FIRST) && (rev6(picked[5:0]) == SYNC_SECOND);
	endfunction

endpackage

[rtl/core/fskid_front.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fskid_front
// Accepts input transactions, decides the window bit and queues the op.
// ---------------------------------------------------------------------------
module fskid_front #(
	parameter int QUEUE_DEPTH = fskid_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  fskid_pkg::in_item_t in_data,
	output logic                op_valid,
	input  logic                op_pop,
	output fskid_pkg::op_t      op_data
);
	import fskid_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

	op_t              mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;
	op_t              op_new;

	assign in_ready = (count_q != CNT_FULL);
	assign push     = in_valid && in_ready;
	assign op_valid = (count_q != '0);
	assign pop      = op_pop && op_valid;
	assign op_data  = mem_q[rd_ptr_q];

	always_comb begin
		op_new.cmd     = cmd_t'(in_data.cmd);
		op_new.bit_val = (in_data.low_tone_power > in_data.high_tone_power);
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= op_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

[rtl/core/fskid_back.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fskid_back
// Sync hunt and character deframing state, with registered result output.
// ---------------------------------------------------------------------------
module fskid_back (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       op_valid,
	output logic                                       op_pop,
	input  fskid_pkg::op_t                             op_data,
	input  logic [fskid_pkg::HUNT_WIDTH-1:0]           hunt_limit,
	input  logic [fskid_pkg::CHAR_CNT_WIDTH-1:0]       char_limit,
	output logic                                       out_valid,
	input  logic                                       out_ready,
	output fskid_pkg::out_item_t                       out_data
);
	import fskid_pkg::*;

	logic [HIST_LEN-1:0]       hist_q,   hist_d;
	logic [HUNT_WIDTH-1:0]     hunt_q,   hunt_d;
	logic                      sync_q,   sync_d;
	logic [2:0]                pos_q,    pos_d;
	logic [5:0]                acc_q,    acc_d;
	logic [CHAR_CNT_WIDTH-1:0] cnt_q,    cnt_d;
	end_status_t               status_q, status_d;
	logic                      emit;
	logic [6:0]                code;
	logic [HIST_LEN-1:0]       hist_new;
	logic [HUNT_WIDTH:0]       hunt_next;
	logic [5:0]                acc_new;
	logic [2:0]                pos_inc;
	logic                      out_valid_q;
	out_item_t                 out_q;

	assign op_pop    = op_valid && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign hist_new  = {hist_q[HIST_LEN-2:0], op_data.bit_val};
	assign hunt_next = {1'b0, hunt_q} + (HUNT_WIDTH+1)'(1);
	assign acc_new   = acc_q | (6'(op_data.bit_val) << pos_q);
	assign pos_inc   = pos_q + 3'd1;

	always_comb begin
		hist_d   = hist_q;
		hunt_d   = hunt_q;
		sync_d   = sync_q;
		pos_d    = pos_q;
		acc_d    = acc_q;
		cnt_d    = cnt_q;
		status_d = status_q;
		emit     = 1'b0;
		code     = '0;
		if (op_data.cmd == CMD_RESTART) begin
			hist_d   = '0;
			hunt_d   = '0;
			sync_d   = 1'b0;
			pos_d    = '0;
			acc_d    = '0;
			cnt_d    = '0;
			status_d = ST_RUNNING;
		end else if (status_q == ST_RUNNING) begin
			if (!sync_q) begin
				hist_d = hist_new;
				if (sync_hit(hist_new)) begin
					sync_d = 1'b1;
					acc_d  = '0;
					pos_d  = '0;
					cnt_d  = '0;
				end
				hunt_d = hunt_next[HUNT_WIDTH] ? HUNT_SAT : hunt_next[HUNT_WIDTH-1:0];
				if (hunt_next > {1'b0, hunt_limit}) begin
					status_d = ST_HUNT_TIMEOUT;
				end
			end else begin
				acc_d = acc_new;
				pos_d = pos_inc;
				if (pos_inc == BITS_PER_CHAR) begin
					if (acc_new < TERM_BELOW) begin
						status_d = ST_TERMINATOR;
					end else if (cnt_q >= char_limit) begin
						status_d = ST_CHAR_LIMIT;
					end else begin
						emit  = 1'b1;
						code  = {1'b0, acc_new} + ASCII_OFFSET;
						cnt_d = cnt_q + CHAR_CNT_WIDTH'(1);
						pos_d = '0;
						acc_d = '0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q      <= '0;
			hunt_q      <= '0;
			sync_q      <= 1'b0;
			pos_q       <= '0;
			acc_q       <= '0;
			cnt_q       <= '0;
			status_q    <= ST_RUNNING;
			out_valid_q <= 1'b0;
		end else begin
			if (op_pop) begin
				hist_q   <= hist_d;
				hunt_q   <= hunt_d;
				sync_q   <= sync_d;
				pos_q    <= pos_d;
				acc_q    <= acc_d;
				cnt_q    <= cnt_d;
				status_q <= status_d;
			end
			if (op_pop) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (op_pop) begin
			out_q.char_valid       <= emit;
			out_q.char_code        <= code;
			out_q.synced           <= sync_d;
			out_q.status           <= status_d;
			out_q.full_bit_advance <= sync_d;
			out_q.char_total       <= cnt_d;
		end
	end

endmodule

[rtl/core/fsk_id_sync_and_char_deframer.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fsk_id_sync_and_char_deframer
// FSK identifier sync hunter and 6-bit character deframer.
// ---------------------------------------------------------------------------
// channel | signals                          | direction
// in      | in_valid / in_ready / in_data    | windows or restart in
// out     | out_valid / out_ready / out_data | one result per input
// cfg     | cfg_valid / cfg_ready / cfg_*    | register writes
//
// one transaction per cycle in and out while neither side stalls; each input
// passes through a QUEUE_DEPTH op queue and then one output register.
// reset clears all control state, loads hunt_limit 200 and char_limit 10.
// the front stalls only when the op queue is full; the back stalls only
// while the output register holds an untaken result. cfg is always ready.
// ---------------------------------------------------------------------------
module fsk_id_sync_and_char_deframer #(
	parameter int QUEUE_DEPTH = fskid_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  fskid_pkg::in_item_t                    in_data,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output fskid_pkg::out_item_t                   out_data,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  fskid_pkg::cfg_index_t                  cfg_index,
	input  logic [fskid_pkg::CFG_DATA_WIDTH-1:0]   cfg_data
);
	import fskid_pkg::*;

	logic [HUNT_WIDTH-1:0]     hunt_limit_q;
	logic [CHAR_CNT_WIDTH-1:0] char_limit_q;
	logic                      op_valid;
	logic                      op_pop;
	op_t                       op_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hunt_limit_q <= HUNT_LIMIT_RST;
			char_limit_q <= CHAR_LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_HUNT_LIMIT: hunt_limit_q <= cfg_data[HUNT_WIDTH-1:0];
				CFG_CHAR_LIMIT: char_limit_q <= cfg_data[CHAR_CNT_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	fskid_front #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.op_valid (op_valid),
		.op_pop   (op_pop),
		.op_data  (op_data)
	);

	fskid_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.op_valid   (op_valid),
		.op_pop     (op_pop),
		.op_data    (op_data),
		.hunt_limit (hunt_limit_q),
		.char_limit (char_limit_q),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

endmodule

[rtl/core/fskid_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fskid_checker
// Port-level assertions for the fsk identifier deframer.
// ---------------------------------------------------------------------------
module fskid_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 out_valid,
	input logic                 out_ready,
	input fskid_pkg::out_item_t out_data
);
	import fskid_pkg::*;

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// code is zero without a character
	a_code_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.char_valid |-> out_data.char_code == 7'd0)
		else $error("char_code set without char_valid");

	// advance follows sync
	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.full_bit_advance == out_data.synced)
		else $error("full_bit_advance differs from synced");

	// characters only while synced and running, at least one counted
	a_char_ctx: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.char_valid |->
			out_data.synced && out_data.status == ST_RUNNING &&
			out_data.char_total != '0)
		else $error("character emitted outside decoding");

endmodule

bind fsk_id_sync_and_char_deframer fskid_checker u_fskid_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

[test/testbench.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Checks the fsk identifier deframer against a cycle-free model of its
// sync hunt and character assembly. Directed tasks cover power extremes,
// sync found on a partly filled history, sync on the timeout window, zero
// and extreme limits, a full-length hunt and windows after the end; random
// sequences of restart, noise, sync words (some corrupted) and characters
// follow under several register settings. Both sides stall at random.
// ---------------------------------------------------------------------------
module testbench;
	import fskid_pkg::*;

	localparam int CYCLE_LIMIT = 600000;
	localparam logic [11:0] SYNC_WORD = {SYNC_SECOND, SYNC_FIRST};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b1;
	out_item_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	cfg_index_t cfg_index = CFG_HUNT_LIMIT;
	logic [CFG_DATA_WIDTH-1:0] cfg_data = '0;

	// decoder state as the block should hold it
	logic [HIST_LEN-1:0] bits_seen = '0;
	logic [HUNT_WIDTH-1:0] hunt_windows = '0;
	logic locked = 1'b0;
	logic [2:0] bit_slot = '0;
	logic [5:0] char_bits = '0;
	logic [CHAR_CNT_WIDTH-1:0] chars_out = '0;
	end_status_t decode_end = ST_RUNNING;
	logic [HUNT_WIDTH-1:0] hunt_limit_reg = HUNT_LIMIT_RST;
	logic [CHAR_CNT_WIDTH-1:0] char_limit_reg = CHAR_LIMIT_RST;

	out_item_t deframer_outputs_due[$];
	out_item_t want;
	int mismatches = 0;
	int live_items = 0;
	int quiet_left = 0;
	logic calm = 1'b0;

	fsk_id_sync_and_char_deframer dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic out_item_t deframe_window(input in_item_t item);
		out_item_t res;
		logic b;
		logic [11:0] taps;
		logic [5:0] first_grp;
		logic [5:0] second_grp;
		logic [HUNT_WIDTH:0] nxt;
		res = '0;
		if (item.cmd == CMD_RESTART) begin
			bits_seen = '0;
			hunt_windows = '0;
			locked = 1'b0;
			bit_slot = '0;
			char_bits = '0;
			chars_out = '0;
			decode_end = ST_RUNNING;
		end else if (decode_end == ST_RUNNING) begin
			b = item.low_tone_power > item.high_tone_power;
			if (!locked) begin
				bits_seen = {bits_seen[HIST_LEN-2:0], b};
				for (int i = 0; i < 12; i++) begin
					taps[11-i] = bits_seen[23-2*i];
				end
				for (int k = 0; k < 6; k++) begin
					first_grp[5-k] = taps[6+k];
					second_grp[5-k] = taps[k];
				end
				if (first_grp == SYNC_FIRST && second_grp == SYNC_SECOND) begin
					locked = 1'b1;
					char_bits = '0;
					bit_slot = '0;
					chars_out = '0;
				end
				nxt = {1'b0, hunt_windows} + 11'd1;
				hunt_windows = (nxt > 11'd1023) ? HUNT_SAT : nxt[HUNT_WIDTH-1:0];
				if (nxt > {1'b0, hunt_limit_reg})
					decode_end = ST_HUNT_TIMEOUT;
			end else begin
				char_bits = char_bits | (6'(b) << bit_slot);
				bit_slot = bit_slot + 3'd1;
				if (bit_slot == BITS_PER_CHAR) begin
					if (char_bits < TERM_BELOW) begin
						decode_end = ST_TERMINATOR;
					end else if (chars_out >= char_limit_reg) begin
						decode_end = ST_CHAR_LIMIT;
					end else begin
						res.char_valid = 1'b1;
						res.char_code = {1'b0, char_bits} + ASCII_OFFSET;
						chars_out = chars_out + 1'b1;
						bit_slot = '0;
						char_bits = '0;
					end
				end
			end
		end
		res.synced = locked;
		res.status = decode_end;
		res.full_bit_advance = locked;
		res.char_total = chars_out;
		return res;
	endfunction

	function automatic void compare_field(input string field, input logic [7:0] want_v,
			input logic [7:0] got_v);
		if (want_v !== got_v) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want_v, got_v);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (deframer_outputs_due.size() == 0) begin
				$display("%0t: unexpected transaction, expected none, actual %h", $time, out_data);
				mismatches++;
			end else begin
				want = deframer_outputs_due.pop_front();
				compare_field("char_valid", 8'(want.char_valid), 8'(out_data.char_valid));
				compare_field("char_code", 8'(want.char_code), 8'(out_data.char_code));
				compare_field("synced", 8'(want.synced), 8'(out_data.synced));
				compare_field("status", 8'(want.status), 8'(out_data.status));
				compare_field("full_bit_advance", 8'(want.full_bit_advance),
					8'(out_data.full_bit_advance));
				compare_field("char_total", 8'(want.char_total), 8'(out_data.char_total));
			end
		end
	end

	// receiver stalls
	initial begin
		forever begin
			@(negedge clk);
			if (!calm && arst_n && $urandom_range(0, 11) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(negedge clk);
				out_ready <= 1'b1;
			end else if ($urandom_range(0, 40) == 0) begin
				repeat ($urandom_range(20, 60)) @(negedge clk);
			end
		end
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("fsk_id_sync_and_char_deframer verification failed");
		$finish;
	end

	task automatic send_item(input in_item_t it);
		@(negedge clk);
		if (quiet_left > 0) begin
			quiet_left--;
		end else if (!calm && $urandom_range(0, 9) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(negedge clk);
		end else if ($urandom_range(0, 30) == 0) begin
			quiet_left = $urandom_range(20, 60);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (!in_ready);
		if (it.cmd == CMD_RESTART || decode_end == ST_RUNNING)
			live_items++;
		deframer_outputs_due.push_back(deframe_window(it));
	endtask

	task automatic hold_until_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (deframer_outputs_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_WIDTH-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_HUNT_LIMIT)
			hunt_limit_reg = val[HUNT_WIDTH-1:0];
		else
			char_limit_reg = val[CHAR_CNT_WIDTH-1:0];
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic configure(input logic [CFG_DATA_WIDTH-1:0] hunt,
			input logic [CFG_DATA_WIDTH-1:0] chr);
		hold_until_drained();
		write_reg(CFG_HUNT_LIMIT, hunt);
		write_reg(CFG_CHAR_LIMIT, chr);
	endtask

	function automatic in_item_t power_item(input logic [POWER_WIDTH-1:0] lo,
			input logic [POWER_WIDTH-1:0] hi);
		in_item_t it;
		it.cmd = CMD_WINDOW;
		it.low_tone_power = lo;
		it.high_tone_power = hi;
		return it;
	endfunction

	function automatic in_item_t window_item(input logic want_bit);
		logic [POWER_WIDTH-1:0] a;
		logic [POWER_WIDTH-1:0] b;
		logic [POWER_WIDTH-1:0] t;
		a = $urandom;
		b = $urandom;
		case ($urandom_range(0, 7))
			0: b = a;
			1: begin
				a = 32'(a[7:0]);
				b = 32'(b[7:0]);
			end
			2: b = a ^ (32'd1 << $urandom_range(0, 31));
			default: ;
		endcase
		if (want_bit ? (a < b) : (a > b)) begin
			t = a;
			a = b;
			b = t;
		end
		if (want_bit && a == b) begin
			if (a == '1)
				b = a - 1'b1;
			else
				a = a + 1'b1;
		end
		return power_item(a, b);
	endfunction

	task automatic send_window(input logic want_bit);
		send_item(window_item(want_bit));
	endtask

	task automatic send_restart();
		in_item_t it;
		it.cmd = CMD_RESTART;
		it.low_tone_power = $urandom;
		it.high_tone_power = $urandom;
		send_item(it);
	endtask

	// each sync bit sits on the older window of a half-bit pair
	task automatic send_sync(input logic [11:0] word, input int first);
		for (int i = first; i < 12; i++) begin
			send_window(word[i]);
			send_window(1'($urandom_range(0, 1)));
		end
	endtask

	task automatic send_char(input logic [5:0] code);
		for (int i = 0; i < 6; i++) begin
			send_window(code[i]);
		end
	endtask

	function automatic logic [5:0] random_code();
		if ($urandom_range(0, 9) == 0)
			return 6'($urandom_range(0, TERM_BELOW - 1));
		return 6'($urandom_range(TERM_BELOW, 6'h3F));
	endfunction

	task automatic test_power_extremes();
		send_restart();
		send_item(power_item('0, '0));
		send_item(power_item('1, '1));
		send_item(power_item('1, '0));
		send_item(power_item('0, '1));
		send_item(power_item(32'd1, '0));
		send_item(power_item('1, 32'hFFFF_FFFE));
		send_item(power_item(32'h5555_5555, 32'hAAAA_AAAA));
		send_item(power_item(32'hAAAA_AAAA, 32'h5555_5555));
	endtask

	// leading sync zeros come from the empty history
	task automatic test_short_history_sync();
		send_restart();
		send_sync(SYNC_WORD, 5);
		send_char(6'h21);
		send_char(6'h3F);
		send_char(TERM_BELOW);
		send_char(TERM_BELOW - 1'b1);
	endtask

	task automatic test_sync_at_timeout();
		configure(10'd13, 10'd10);
		send_restart();
		send_sync(SYNC_WORD, 5);
		send_window(1'b1);
		send_restart();
	endtask

	task automatic test_zero_limits();
		configure(10'd0, 10'd10);
		send_restart();
		send_window(1'b1);
		send_window(1'b0);
		configure(10'd200, 10'd0);
		send_restart();
		send_sync(SYNC_WORD, 0);
		send_char(6'h30);
		send_restart();
		send_sync(SYNC_WORD, 0);
		send_char(6'h00);
	endtask

	task automatic test_char_limit_extremes();
		configure(10'd200, 10'd1);
		send_restart();
		send_sync(SYNC_WORD, 0);
		repeat (2) send_char(6'($urandom_range(TERM_BELOW, 6'h3F)));
		configure(10'd200, 10'h3F0 | 10'd15);
		send_restart();
		send_sync(SYNC_WORD, 0);
		repeat (16) send_char(6'($urandom_range(TERM_BELOW, 6'h3F)));
	endtask

	task automatic test_long_hunt();
		configure(10'd100, 10'd15);
		send_restart();
		repeat (100) send_window(1'b0);
		send_window(1'b1);
	endtask

	task automatic run_sequence();
		logic [11:0] word;
		int n;
		if ($urandom_range(0, 9) != 0)
			send_restart();
		repeat ($urandom_range(0, 6)) send_window(1'($urandom_range(0, 1)));
		word = SYNC_WORD;
		if ($urandom_range(0, 4) == 0)
			word[$urandom_range(0, 11)] ^= 1'b1;
		send_sync(word, ($urandom_range(0, 3) == 0) ? 5 : 0);
		n = $urandom_range(1, 17);
		while (n > 0 && decode_end == ST_RUNNING) begin
			if ($urandom_range(0, 29) == 0) begin
				repeat ($urandom_range(1, 5)) send_window(1'($urandom_range(0, 1)));
				send_restart();
				n = 0;
			end else begin
				send_char(random_code());
				n--;
			end
		end
		repeat ($urandom_range(0, 2)) send_window(1'($urandom_range(0, 1)));
		if ($urandom_range(0, 19) == 0)
			hold_until_drained();
	endtask

	task automatic test_random_sequences();
		int target;
		logic [HUNT_WIDTH-1:0] hunt;
		logic [CHAR_CNT_WIDTH-1:0] chr;
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: begin
					hunt = 10'd1023;
					chr = 4'd15;
				end
				1: begin
					hunt = HUNT_WIDTH'($urandom_range(40, 120));
					chr = 4'd1;
				end
				2: begin
					hunt = HUNT_WIDTH'($urandom_range(24, 40));
					chr = CHAR_CNT_WIDTH'($urandom_range(0, 15));
				end
				3: begin
					hunt = HUNT_WIDTH'($urandom_range(100, 1023));
					chr = CHAR_CNT_WIDTH'($urandom_range(1, 15));
				end
				4: begin
					hunt = HUNT_WIDTH'($urandom_range(30, 1023));
					chr = CHAR_CNT_WIDTH'($urandom_range(0, 15));
				end
				default: begin
					hunt = HUNT_LIMIT_RST;
					chr = CHAR_LIMIT_RST;
				end
			endcase
			configure(hunt, {6'($urandom_range(0, 63)), chr});
			if (phase == 5)
				calm = 1'b1;
			target = live_items + 60;
			while (live_items < target) run_sequence();
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_power_extremes();
		test_short_history_sync();
		test_sync_at_timeout();
		test_zero_limits();
		test_char_limit_extremes();
		test_long_hunt();
		test_random_sequences();
		hold_until_drained();
		if (mismatches == 0 && deframer_outputs_due.size() == 0)
			$display("fsk_id_sync_and_char_deframer verification clean");
		else
			$display("fsk_id_sync_and_char_deframer verification failed");
		$finish;
	end

endmodule

[sim.f]
rtl/core/fskid_pkg.sv
rtl/core/fskid_front.sv
rtl/core/fskid_back.sv
rtl/core/fsk_id_sync_and_char_deframer.sv
rtl/core/fskid_checker.sv
test/testbench.sv
